// ===== hw/rtl/lkvc_pkg.sv =====
// Shared request, result and control types for the LRU key/value cache.
package lkvc_pkg;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    localparam int                   CAP_WIDTH    = 5;
    localparam logic [CAP_WIDTH-1:0] CAP_RESET    = 5'd16;
    localparam logic                 REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } rsp_t;

    typedef struct packed {
        logic start_scan;
        logic start_update;
        logic in_update;
        logic commit;
    } cmd_t;

endpackage

// ===== hw/rtl/lru_key_value_cache.sv =====
// Top level of the LRU key/value cache: capacity register, controller and datapath.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-------------------------------------------
//   request   | start, busy          | request (mode, key, value)
//   result    | done (one-cycle)     | result (hit, read_value, evicted, evicted_key)
//   config    | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// A request is taken when start is high and busy is low; busy then stays high
// through a lookup sweep and an age update sweep over the entry memories, one
// entry per cycle with registered reads, and through a commit state; done pulses
// in the first cycle with busy low again.
// Reset clears all entries at once through the valid bits; no clearing pass.
// The receiver cannot stall: done marks each result for exactly one cycle.
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  req_t        request,
    output logic        busy,
    output logic        done,
    output rsp_t        result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(ENTRIES + 1);

    logic [CAP_WIDTH-1:0] capacity_reg, capacity_next;
    logic [CW-1:0]        eff_cap;
    logic                 cfg_write;
    logic                 pass_done;
    cmd_t                 cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

    always_comb
    begin
        capacity_next = capacity_reg;
        if (cfg_write)
        begin
            capacity_next = pwdata[CAP_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity_reg) : '0;

    always_comb
    begin
        priority if (capacity_reg == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (32'(capacity_reg) > 32'(ENTRIES))
        begin
            eff_cap = CW'(ENTRIES);
        end
        else
        begin
            eff_cap = CW'(capacity_reg);
        end
    end

    lkvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .pass_done (pass_done),
        .busy      (busy),
        .cmd       (cmd)
    );

    lkvc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .request   (request),
        .eff_cap   (eff_cap),
        .pass_done (pass_done),
        .done      (done),
        .result    (result)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a request is in flight");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not make the block busy");

    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.evicted) |-> !result.hit)
        else $error("eviction reported on a hit");

    a_read_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.read_value != '0)) |-> result.hit)
        else $error("read value returned without a hit");

endmodule

// ===== hw/rtl/lkvc_ctrl.sv =====
// Controller state machine sequencing the lookup sweep, age update sweep and commit.
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic pass_done,
    output logic busy,
    output cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.start_scan = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (pass_done)
                begin
                    cmd.start_update = 1'b1;
                    state_next       = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.in_update = 1'b1;
                if (pass_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== hw/rtl/lkvc_datapath.sv =====
// Datapath: entry memories, valid bits, sweep counter, match and LRU tracking, result register.
module lkvc_datapath
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cmd_t                           cmd,
    input  req_t                           request,
    input  logic [$clog2(ENTRIES+1)-1:0]   eff_cap,
    output logic                           pass_done,
    output logic                           done,
    output rsp_t                           result
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AW = IW;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    logic [31:0]   key_mem_reg [ENTRIES];
    logic [31:0]   val_mem_reg [ENTRIES];
    logic [AW-1:0] age_mem_reg [ENTRIES];

    req_t          req_reg;
    logic [31:0]   key_rd_reg;
    logic [31:0]   val_rd_reg;
    logic [AW-1:0] age_rd_reg;

    logic          issue_reg, issue_next;
    logic [IW-1:0] addr_reg, addr_next;
    logic          data_vld_reg, data_vld_next;
    logic [IW-1:0] data_idx_reg;

    logic          found_reg, found_next;
    logic [IW-1:0] hit_idx_reg;
    logic [AW-1:0] hit_age_reg;
    logic [31:0]   hit_val_reg;
    logic          lru_found_reg, lru_found_next;
    logic [IW-1:0] lru_idx_reg;
    logic [31:0]   lru_key_reg;
    logic          free_found_reg, free_found_next;
    logic [IW-1:0] free_idx_reg;

    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               done_reg, done_next;
    rsp_t               result_reg, result_next;

    logic          is_put;
    logic          insert;
    logic          evict;
    logic          slot_ok;
    logic [IW-1:0] slot_idx;
    logic          cur_valid;
    logic          scan_step;
    logic          upd_step;
    logic          key_match;
    logic          lru_match;
    logic          age_we;
    logic [IW-1:0] age_widx;
    logic [AW-1:0] age_wdata;
    logic          val_we;
    logic [IW-1:0] val_widx;
    logic          key_we;

    assign is_put   = (req_reg.mode == MODE_PUT);
    assign insert   = is_put && !found_reg;
    assign evict    = insert && lru_found_reg && (count_reg >= eff_cap);
    assign slot_ok  = free_found_reg || evict;
    assign slot_idx = (free_found_reg && (!evict || (free_idx_reg < lru_idx_reg)))
                      ? free_idx_reg : lru_idx_reg;

    assign cur_valid = valid_reg[data_idx_reg];
    assign scan_step = data_vld_reg && !cmd.in_update;
    assign upd_step  = data_vld_reg && cmd.in_update;
    assign key_match = cur_valid && (key_rd_reg == req_reg.key);
    assign lru_match = cur_valid && (CW'(age_rd_reg) == (count_reg - CW'(1)));
    assign pass_done = data_vld_reg && (data_idx_reg == LAST);

    // sweep address generator
    always_comb
    begin
        issue_next    = issue_reg;
        addr_next     = addr_reg;
        data_vld_next = issue_reg;
        if (cmd.start_scan || cmd.start_update)
        begin
            issue_next = 1'b1;
            addr_next  = '0;
        end
        else if (issue_reg)
        begin
            if (addr_reg == LAST)
            begin
                issue_next = 1'b0;
            end
            else
            begin
                addr_next = addr_reg + IW'(1);
            end
        end
    end

    // lookup sweep: track match, least recent entry and first free slot
    always_comb
    begin
        found_next      = found_reg;
        lru_found_next  = lru_found_reg;
        free_found_next = free_found_reg;
        if (cmd.start_scan)
        begin
            found_next      = 1'b0;
            lru_found_next  = 1'b0;
            free_found_next = 1'b0;
        end
        else if (scan_step)
        begin
            if (key_match)
            begin
                found_next = 1'b1;
            end
            if (lru_match)
            begin
                lru_found_next = 1'b1;
            end
            if (!cur_valid)
            begin
                free_found_next = 1'b1;
            end
        end
    end

    // age write port: sweep update, then new entry at commit
    always_comb
    begin
        age_we    = 1'b0;
        age_widx  = data_idx_reg;
        age_wdata = AW'(age_rd_reg + AW'(1));
        if (upd_step && cur_valid)
        begin
            if (insert)
            begin
                age_we = !(evict && (data_idx_reg == lru_idx_reg));
            end
            else if (found_reg)
            begin
                if (data_idx_reg == hit_idx_reg)
                begin
                    age_we    = 1'b1;
                    age_wdata = '0;
                end
                else if (age_rd_reg < hit_age_reg)
                begin
                    age_we = 1'b1;
                end
            end
        end
        else if (cmd.commit && insert && slot_ok)
        begin
            age_we    = 1'b1;
            age_widx  = slot_idx;
            age_wdata = '0;
        end
    end

    assign key_we   = cmd.commit && insert && slot_ok;
    assign val_we   = cmd.commit && is_put && (found_reg || slot_ok);
    assign val_widx = found_reg ? hit_idx_reg : slot_idx;

    always_comb
    begin
        valid_next  = valid_reg;
        count_next  = count_reg;
        done_next   = cmd.commit;
        result_next = result_reg;
        if (cmd.commit)
        begin
            if (insert)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_ok && (slot_idx == IW'(i)))
                    begin
                        valid_next[i] = 1'b1;
                    end
                    else if (evict && (lru_idx_reg == IW'(i)))
                    begin
                        valid_next[i] = 1'b0;
                    end
                end
                count_next = count_reg - CW'(evict) + CW'(slot_ok);
            end
            result_next.hit         = found_reg;
            result_next.read_value  = (!is_put && found_reg) ? hit_val_reg : '0;
            result_next.evicted     = evict;
            result_next.evicted_key = evict ? lru_key_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg      <= 1'b0;
            addr_reg       <= '0;
            data_vld_reg   <= 1'b0;
            found_reg      <= 1'b0;
            lru_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            issue_reg      <= issue_next;
            addr_reg       <= addr_next;
            data_vld_reg   <= data_vld_next;
            found_reg      <= found_next;
            lru_found_reg  <= lru_found_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_idx_reg <= addr_reg;
        result_reg   <= result_next;
        if (cmd.start_scan)
        begin
            req_reg <= request;
        end
        if (scan_step && key_match && !found_reg)
        begin
            hit_idx_reg <= data_idx_reg;
            hit_age_reg <= age_rd_reg;
            hit_val_reg <= val_rd_reg;
        end
        if (scan_step && lru_match && !lru_found_reg)
        begin
            lru_idx_reg <= data_idx_reg;
            lru_key_reg <= key_rd_reg;
        end
        if (scan_step && !cur_valid && !free_found_reg)
        begin
            free_idx_reg <= data_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem_reg[slot_idx] <= req_reg.key;
        end
        if (val_we)
        begin
            val_mem_reg[val_widx] <= req_reg.value;
        end
        if (age_we)
        begin
            age_mem_reg[age_widx] <= age_wdata;
        end
        key_rd_reg <= key_mem_reg[addr_reg];
        val_rd_reg <= val_mem_reg[addr_reg];
        age_rd_reg <= age_mem_reg[addr_reg];
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== verif/tb_lru_key_value_cache.sv =====
// Self-checking testbench for the LRU key/value cache with a built-in recency predictor.
`timescale 1ns / 100ps

module tb_lru_key_value_cache;
    import lkvc_pkg::*;

    localparam int CACHE_ENTRIES  = 16;
    localparam int KEY_POOL_SIZE  = 24;
    localparam int PHASE_REQUESTS = 80;
    localparam int DRAIN_CYCLES   = 2 * CACHE_ENTRIES + 8;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct {
        req_t req;
        int   gap;
    } stim_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    req_t        request = '0;
    logic        busy;
    logic        done;
    rsp_t        result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    stim_t request_queue[$];
    rsp_t  pending_results[$];
    stim_t next_item;

    logic               m_valid [CACHE_ENTRIES];
    logic signed [31:0] m_key   [CACHE_ENTRIES];
    logic signed [31:0] m_value [CACHE_ENTRIES];
    int                 m_age   [CACHE_ENTRIES];
    int                 m_count;
    logic [4:0]         m_capacity;

    logic signed [31:0] key_pool [KEY_POOL_SIZE];

    int          idle_left;
    int          cur_gap;
    int          quiet_cycles;
    int unsigned error_count;
    int unsigned accepted_count;
    int unsigned pushed_count;
    int unsigned result_count;
    int unsigned hit_count;
    int unsigned evict_count;
    int unsigned setting_count;

    lru_key_value_cache #(.ENTRIES(CACHE_ENTRIES)) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int effective_limit(logic [4:0] cap);
        if (cap == 0)
            return 1;
        if (cap > CACHE_ENTRIES)
            return CACHE_ENTRIES;
        return int'(cap);
    endfunction

    function automatic void promote_entry(int h);
        int old;
        old = m_age[h];
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (m_valid[i] && m_age[i] < old)
                m_age[i]++;
        m_age[h] = 0;
    endfunction

    function automatic rsp_t cache_access(req_t r);
        rsp_t o;
        int   h;
        int   slot;
        o    = '0;
        h    = -1;
        slot = -1;
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (h < 0 && m_valid[i] && m_key[i] == r.key)
                h = i;
        if (r.mode == MODE_GET)
        begin
            if (h >= 0)
            begin
                o.hit        = 1'b1;
                o.read_value = m_value[h];
                promote_entry(h);
            end
        end
        else if (h >= 0)
        begin
            o.hit      = 1'b1;
            m_value[h] = r.value;
            promote_entry(h);
        end
        else
        begin
            // evict the least recent entry when the store is at or above its limit
            if (m_count >= effective_limit(m_capacity) && m_count > 0)
            begin
                for (int i = 0; i < CACHE_ENTRIES; i++)
                begin
                    if (!o.evicted && m_valid[i] && m_age[i] == m_count - 1)
                    begin
                        o.evicted     = 1'b1;
                        o.evicted_key = m_key[i];
                        m_valid[i]    = 1'b0;
                        m_count--;
                    end
                end
            end
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                if (m_valid[i])
                    m_age[i]++;
                else if (slot < 0)
                    slot = i;
            end
            if (slot >= 0)
            begin
                m_valid[slot] = 1'b1;
                m_key[slot]   = r.key;
                m_value[slot] = r.value;
                m_age[slot]   = 0;
                m_count++;
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            request   <= '0;
            idle_left = 0;
            cur_gap   = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                pending_results.push_back(cache_access(request));
                accepted_count++;
                idle_left = cur_gap;
            end
            if (start && busy)
            begin
            end
            else if (idle_left > 0)
            begin
                start   <= 1'b0;
                request <= '{mode: 1'($urandom), key: $urandom, value: $urandom};
                if (!busy)
                    idle_left--;
            end
            else if (request_queue.size() > 0)
            begin
                next_item = request_queue.pop_front();
                start     <= 1'b1;
                request   <= next_item.req;
                cur_gap   = next_item.gap;
            end
            else
            begin
                start   <= 1'b0;
                request <= '{mode: 1'($urandom), key: $urandom, value: $urandom};
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            result_count++;
            if (pending_results.size() == 0)
                report_mismatch("result with no request outstanding",
                                result.read_value, 32'd0);
            else
            begin
                rsp_t want;
                want = pending_results.pop_front();
                if (want.hit)
                    hit_count++;
                if (want.evicted)
                    evict_count++;
                if (result.hit !== want.hit)
                    report_mismatch("hit", 32'(result.hit), 32'(want.hit));
                if (result.read_value !== want.read_value)
                    report_mismatch("read_value", result.read_value, want.read_value);
                if (result.evicted !== want.evicted)
                    report_mismatch("evicted", 32'(result.evicted), 32'(want.evicted));
                if (result.evicted_key !== want.evicted_key)
                    report_mismatch("evicted_key", result.evicted_key, want.evicted_key);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no request or result for %0d cycles",
                         $time, WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic push_request(logic mode, logic [31:0] key, logic [31:0] value, int gap);
        stim_t s;
        s.req.mode  = mode;
        s.req.key   = key;
        s.req.value = value;
        s.gap       = gap;
        request_queue.push_back(s);
        pushed_count++;
    endtask

    task automatic wait_drained();
        while (accepted_count != pushed_count || pending_results.size() != 0 || busy)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(logic [4:0] cap);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= {$urandom_range(0, 1) ? 27'($urandom) : 27'd0, cap};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        m_capacity = cap;
        setting_count++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        if (prdata[4:0] !== cap)
            report_mismatch("capacity readback", prdata, 32'(cap));
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        logic [4:0] caps [12];
        int         span;
        int         gap;
        logic [31:0] key;

        caps = '{5'd31, 5'd16, 5'd1, 5'd5, 5'd0, 5'd2, 5'd12, 5'd17, 5'd3, 5'd8, 5'd15, 5'd4};
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            m_valid[i] = 1'b0;
            m_key[i]   = '0;
            m_value[i] = '0;
            m_age[i]   = 0;
        end
        m_count      = 0;
        m_capacity   = CAP_RESET;
        key_pool[0]  = 32'h8000_0000;
        key_pool[1]  = 32'h7FFF_FFFF;
        key_pool[2]  = 32'h0000_0000;
        key_pool[3]  = 32'hFFFF_FFFF;
        for (int i = 4; i < KEY_POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset capacity: misses, inserts at the key extremes, hits, update
        push_request(MODE_GET, 32'h0000_0000, 32'h0000_0000, $urandom_range(0, 13));
        push_request(MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF, $urandom_range(0, 13));
        push_request(MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000, $urandom_range(0, 13));
        push_request(MODE_PUT, 32'h0000_0000, 32'h0000_0000, 0);
        push_request(MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        push_request(MODE_GET, 32'h8000_0000, 32'h0000_0000, $urandom_range(0, 13));
        push_request(MODE_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, $urandom_range(0, 13));
        push_request(MODE_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        push_request(MODE_PUT, 32'h8000_0000, 32'h1234_5678, $urandom_range(0, 13));
        push_request(MODE_GET, 32'h8000_0000, 32'h0000_0000, 0);
        push_request(MODE_GET, 32'h0000_0001, 32'hDEAD_BEEF, $urandom_range(0, 13));
        wait_drained();

        // shrink capacity below the number of held entries
        write_capacity(5'd2);
        @(negedge clk);
        push_request(MODE_PUT, 32'h0000_0001, 32'h0000_0011, 0);
        push_request(MODE_PUT, 32'h0000_0002, 32'h0000_0022, $urandom_range(0, 13));
        push_request(MODE_GET, 32'h0000_0001, 32'h0000_0000, 0);
        push_request(MODE_PUT, 32'h0000_0003, 32'h0000_0033, $urandom_range(0, 13));
        push_request(MODE_GET, 32'h0000_0002, 32'h0000_0000, 0);
        wait_drained();

        // zero capacity behaves as one entry
        write_capacity(5'd0);
        @(negedge clk);
        push_request(MODE_PUT, 32'h0000_0004, 32'h0000_0044, 0);
        push_request(MODE_PUT, 32'h0000_0005, 32'h0000_0055, $urandom_range(0, 13));
        push_request(MODE_GET, 32'h0000_0005, 32'h0000_0000, 0);
        push_request(MODE_GET, 32'h0000_0004, 32'h0000_0000, $urandom_range(0, 13));
        wait_drained();

        foreach (caps[p])
        begin
            write_capacity(caps[p]);
            @(negedge clk);
            span = effective_limit(caps[p]) + $urandom_range(1, 6);
            if (span > KEY_POOL_SIZE)
                span = KEY_POOL_SIZE;
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                gap = (p % 3 == 2) ? 0 : $urandom_range(0, 13);
                key = ($urandom_range(0, 15) == 0) ? $urandom
                                                   : key_pool[$urandom_range(0, span - 1)];
                push_request(($urandom_range(0, 99) < 55) ? MODE_PUT : MODE_GET,
                             key, $urandom, gap);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d requests over %0d capacity settings (zero and above-limit included)",
                 accepted_count, setting_count);
        $display("Saw %0d results: %0d hits, %0d evictions, %0d mismatches",
                 result_count, hit_count, evict_count, error_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_ctrl.sv
hw/rtl/lkvc_datapath.sv
hw/rtl/lru_key_value_cache.sv
verif/tb_lru_key_value_cache.sv
